[design/igd_pkg.sv]
// Package: payload types and shared parameters for the int4 group dequantiser.
package igd_pkg;

  localparam int unsigned NibW = 4;
  localparam int unsigned MagW = 8;
  localparam int unsigned ManW = 24;
  localparam int unsigned ProdW = MagW + ManW;

  typedef struct packed {
    logic [7:0]  packed_byte;
    logic [7:0]  zero_point;
    logic [31:0] scale_bits;
  } igd_in_t;

  typedef struct packed {
    logic [15:0] even_value;
    logic [15:0] odd_value;
  } igd_out_t;

  // Special-case classification of one lane, decided in the first stage.
  typedef enum logic [1:0] {
    LaneNorm = 2'd0,
    LaneZero = 2'd1,
    LaneInf  = 2'd2,
    LaneFix  = 2'd3
  } igd_kind_e;

endpackage

[design/igd_lane.sv]
// One dequantisation lane: exact difference times fp32 scale, registered in stages 1 and 2.
module igd_lane import igd_pkg::*; (
  input  logic                 clk_i,
  input  logic [1:0]           en_i,
  input  logic [NibW-1:0]      nib_i,
  input  logic [7:0]           zp_i,
  input  logic [31:0]          scale_i,
  output logic [15:0]          val_o
);

  // Stage 1: difference magnitude, scale unpacked and normalised, class.
  logic            sgn_d, sgn_q;
  logic [MagW-1:0] mag_d, mag_q;
  logic [ManW-1:0] man_d, man_q;
  logic signed [10:0] exp_d, exp_q;
  igd_kind_e       kind_d, kind_q;
  logic [31:0]     fix_d, fix_q;

  logic signed [9:0] diff;
  logic [7:0]  se;
  logic [22:0] sf;
  logic [4:0]  lz;
  logic [ManW-1:0] nm;

  always_comb begin
    diff = signed'({6'd0, nib_i}) - signed'({2'd0, zp_i});
    se = scale_i[30:23];
    sf = scale_i[22:0];
    sgn_d = scale_i[31] ^ diff[9];
    mag_d = diff[9] ? MagW'(-diff) : MagW'(diff);
    lz = 5'd0;
    for (int k = 22; k >= 0; k--) begin
      if (sf[k] && lz == 5'd0 && !(|(sf >> (k + 1)))) lz = 5'(22 - k);
    end
    nm = {1'b0, sf} << (lz + 5'd1);
    if (se == 8'd0) begin
      man_d = nm;
      exp_d = -11'sd127 - signed'({6'd0, lz});
    end else begin
      man_d = {1'b1, sf};
      exp_d = signed'({3'd0, se}) - 11'sd127;
    end
    fix_d = '0;
    if (se == 8'hFF && sf != '0) begin
      kind_d = LaneFix;
      fix_d = scale_i | 32'h0040_0000;
    end else if (se == 8'hFF) begin
      if (mag_d == '0) begin
        kind_d = LaneFix;
        fix_d = 32'hFFC0_0000;
      end else begin
        kind_d = LaneInf;
      end
    end else if (mag_d == '0 || (se == 8'd0 && sf == '0)) begin
      kind_d = LaneZero;
    end else begin
      kind_d = LaneNorm;
    end
  end

  // Stage 2: integer product.
  logic            sgn2_q;
  logic [ProdW-1:0] prod_q;
  logic signed [10:0] exp2_q;
  igd_kind_e       kind2_q;
  logic [31:0]     fix2_q;

  // Stage 3: normalise, round, pack.
  logic [5:0]  p_lz;
  logic [ProdW-1:0] pn;
  logic signed [11:0] e;
  logic [ProdW-1:0] shd;
  logic [5:0]  rs;
  logic        sticky;
  logic [24:0] mr;
  logic [31:0] res;
  logic [31:0] res_d, res_q;

  always_comb begin
    p_lz = 6'd0;
    for (int k = ProdW - 1; k >= 0; k--) begin
      if (prod_q[k] && !(|(prod_q >> (k + 1)))) p_lz = 6'(ProdW - 1 - k);
    end
    pn = prod_q << p_lz;
    // value = pn * 2^(exp - 23 + 31 - 31): leading bit of pn has weight exp+8-p_lz
    e = 12'(exp2_q) + 12'sd8 - signed'({6'd0, p_lz});
    shd = pn;
    sticky = 1'b0;
    if (e < -12'sd126) begin
      rs = (e < -12'sd160) ? 6'd34 : 6'(-12'sd126 - e);
      for (int k = 0; k < ProdW; k++) begin
        if (k < rs && pn[k]) sticky = 1'b1;
      end
      shd = (rs >= 6'd32) ? '0 : (pn >> rs);
      e = -12'sd127;
    end
    // shd[31:8] mantissa (with leading), bit 7 guard, rest sticky
    sticky = sticky | (|shd[6:0]);
    mr = {1'b0, shd[31:8]} +
         25'(shd[7] && (sticky || shd[8]));
    if (mr[24]) begin
      mr = mr >> 1;
      e = e + 12'sd1;
    end
    if (e == -12'sd127 && mr[23]) e = -12'sd126;
    if (e > 12'sd127) begin
      res = {sgn2_q, 8'hFF, 23'd0};
    end else if (e == -12'sd127) begin
      res = {sgn2_q, 8'd0, mr[22:0]};
    end else begin
      res = {sgn2_q, 8'(e + 12'sd127), mr[22:0]};
    end
    case (kind2_q)
      LaneZero: res_d = {sgn2_q, 31'd0};
      LaneInf:  res_d = {sgn2_q, 8'hFF, 23'd0};
      LaneFix:  res_d = fix2_q;
      default:  res_d = res;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sgn_q <= sgn_d; mag_q <= mag_d; man_q <= man_d;
      exp_q <= exp_d; kind_q <= kind_d; fix_q <= fix_d;
    end
    if (en_i[1]) begin
      sgn2_q <= sgn_q; prod_q <= ProdW'(mag_q) * ProdW'(man_q);
      exp2_q <= exp_q; kind2_q <= kind_q; fix2_q <= fix_q;
    end
  end

  // Final register sits in the top level enable domain (third stage).
  assign res_q = res_d;
  assign val_o = res_q[31:16];

endmodule

[design/int4_group_dequant_to_bf16.sv]
// Top level: streaming AWQ int4 group dequantiser to bfloat16.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one packed weight
// byte with its group zero point and fp32 scale; output channel
// (out_valid_o / out_stall_i / out_data_o) returns two bfloat16 values.
// Each lane computes (nibble - zero) * scale as an exact fp32 multiply with
// round-to-nearest-even, then keeps the upper 16 bits.
// The result passes through the stage 1, stage 2 and output registers before
// it is presented on out_data_o.
// Throughput: one request per cycle while the output is not stalled; the 8x24
// mantissa multiplier in stage 2 sets the stage depth.
// Each stage advances when it is empty or the stage after it moves, so a
// stall at the output holds every full stage and loses nothing. The input is
// stalled only when the whole pipeline is full and the output is stalled.
// Reset clears all valid bits; payload registers are not reset.
module int4_group_dequant_to_bf16 import igd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  igd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output igd_out_t out_data_o
);

  logic [2:0] vld_q;
  logic [2:0] adv;
  logic [15:0] ev, od;
  igd_out_t out_q;

  assign adv[2] = !vld_q[2] || !out_stall_i;
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign in_stall_o = !adv[0];

  igd_lane u_even (
    .clk_i, .en_i(adv[1:0]), .nib_i(in_data_i.packed_byte[3:0]),
    .zp_i(in_data_i.zero_point), .scale_i(in_data_i.scale_bits), .val_o(ev)
  );
  igd_lane u_odd (
    .clk_i, .en_i(adv[1:0]), .nib_i(in_data_i.packed_byte[7:4]),
    .zp_i(in_data_i.zero_point), .scale_i(in_data_i.scale_bits), .val_o(od)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) out_q <= '{even_value: ev, odd_value: od};
  end

  assign out_valid_o = vld_q[2];
  assign out_data_o = out_q;

endmodule

[design/igd_checker.sv]
// Port-level checker for the dequantiser, bound to the top level.
module igd_checker import igd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input igd_out_t out_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_nostall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without output stall");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o)
    else $error("result missing after three cycles");

endmodule

bind int4_group_dequant_to_bf16 igd_checker u_igd_checker (.*);

[bench/int4_group_dequant_to_bf16_chk.sv]
// Checker: predicts the bfloat16 pair for each accepted request and compares results.
`timescale 1ns / 1ps
module int4_group_dequant_to_bf16_chk import igd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  igd_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  igd_out_t out_data_i,
  output int       pending_o,
  output int       errors_o
);

  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] ExpMask    = 32'h7F80_0000;
  localparam logic [31:0] FracMask   = 32'h007F_FFFF;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;

  igd_out_t bf16_pairs_q[$];
  int       mismatches;

  // Exact fp32 product (nib - zp) * scale, round to nearest even, denormals kept.
  function automatic logic [31:0] scaled_weight(logic [3:0] nib, logic [7:0] zp,
                                                logic [31:0] sb);
    int           diff;
    logic         sgn;
    longint       mag;
    longint       mant;
    longint       prod;
    longint       q;
    longint       rem;
    longint       half;
    int           eff_exp;
    int           msb;
    int           bexp;
    int           sh;
    longint       bits;
    if ((sb & ExpMask) == ExpMask && (sb & FracMask) != 0) return sb | QuietBit;
    diff = int'(nib) - int'(zp);
    if (diff == 0 && sb[30:0] == ExpMask[30:0]) return DefaultNan;
    sgn = sb[31] ^ (diff < 0);
    mag = (diff < 0) ? longint'(-diff) : longint'(diff);
    if (sb[30:0] == ExpMask[30:0]) return {sgn, ExpMask[30:0]};
    if (mag == 0 || sb[30:0] == 31'd0) return {sgn, 31'd0};
    if (sb[30:23] == 8'd0) begin
      mant = longint'(sb[22:0]);
      eff_exp = 1;
    end else begin
      mant = longint'({1'b1, sb[22:0]});
      eff_exp = int'(sb[30:23]);
    end
    prod = mag * mant;
    msb = 0;
    for (int i = 0; i < 40; i++) if (prod[i]) msb = i;
    bexp = msb + eff_exp - 23;
    if (bexp < 1) bexp = 1;
    sh = bexp - eff_exp;
    if (sh <= 0) begin
      q = prod << (-sh);
    end else begin
      q = prod >> sh;
      rem = prod & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
    end
    bits = (longint'(bexp - 1) << 23) + q;
    if (bits >= longint'(ExpMask)) return {sgn, ExpMask[30:0]};
    return {sgn, bits[30:0]};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    igd_out_t want;
    igd_out_t pred;
    if (!rst_ni) begin
      bf16_pairs_q.delete();
      mismatches <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        pred.even_value = 16'(scaled_weight(in_data_i.packed_byte[3:0],
                                            in_data_i.zero_point,
                                            in_data_i.scale_bits) >> 16);
        pred.odd_value  = 16'(scaled_weight(in_data_i.packed_byte[7:4],
                                            in_data_i.zero_point,
                                            in_data_i.scale_bits) >> 16);
        bf16_pairs_q.push_back(pred);
      end
      if (out_valid_i && !out_stall_i) begin
        if (bf16_pairs_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result even=%h odd=%h", out_data_i.even_value,
                     out_data_i.odd_value);
          mismatches <= mismatches + 1;
        end else begin
          want = bf16_pairs_q.pop_front();
          if (want.even_value !== out_data_i.even_value ||
              want.odd_value !== out_data_i.odd_value) begin
            if (mismatches < 10)
              $display("mismatch: expected even=%h odd=%h, got even=%h odd=%h",
                       want.even_value, want.odd_value,
                       out_data_i.even_value, out_data_i.odd_value);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  assign pending_o = bf16_pairs_q.size();
  assign errors_o  = mismatches + bf16_pairs_q.size();

endmodule

[bench/int4_group_dequant_to_bf16_tb.sv]
// Testbench top: drives requests and stalls, and reports the verdict.
`timescale 1ns / 1ps
module int4_group_dequant_to_bf16_tb;
  import igd_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  igd_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  igd_out_t out_data;
  int       pending;
  int       errors;
  int       burst_left;

  int4_group_dequant_to_bf16 i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  int4_group_dequant_to_bf16_chk i_chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver stall: switch between free-flowing, light and heavy stalling.
  initial begin
    int mode;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 80)) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  // Hold the request until accepted; gaps fall between bursts.
  task automatic send_request(logic [7:0] pb, logic [7:0] zp, logic [31:0] sb);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{packed_byte: pb, zero_point: zp, scale_bits: sb};
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] random_scale();
    logic [31:0] sb;
    sb = $urandom();
    case ($urandom_range(0, 9))
      0: sb[30:23] = 8'd0;
      1: sb[30:23] = 8'hFF;
      2: sb[30:23] = 8'd255 - 8'($urandom_range(1, 8));
      3: sb[30:23] = 8'($urandom_range(1, 8));
      4: sb[30:0] = {8'hFF, 23'd0};
      5: sb[30:0] = 31'd0;
      default: sb[30:23] = 8'($urandom_range(100, 150));
    endcase
    return sb;
  endfunction

  initial begin
    logic [31:0] scales[12];
    logic [7:0]  zp;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zeros, infinities, NaNs, denormals, overflow, field extremes.
    scales = '{32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
               32'h7FA0_0001, 32'hFF80_0001, 32'h0000_0001, 32'h807F_FFFF,
               32'h7F7F_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h3FC0_0001};
    foreach (scales[i]) send_request(8'h0F, (i % 2) ? 8'd15 : 8'd0, scales[i]);
    send_request(8'hFF, 8'hFF, 32'h7F7F_FFFF);
    send_request(8'h00, 8'hFF, 32'hFFFF_FFFF);
    send_request(8'hA5, 8'd5, 32'hFF80_0000);
    send_request(8'h5A, 8'd10, 32'h7F80_0000);
    send_request(8'h77, 8'd7, 32'h4049_0FDB);
    send_request(8'h00, 8'd0, 32'h0040_0000);
    send_request(8'hF0, 8'd128, 32'h3DCC_CCCD);

    repeat (1400) begin
      zp = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 15));
      send_request(8'($urandom()), zp, random_scale());
    end
    in_valid <= 1'b0;
    // Let the checker take the last request before looking at the queue.
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
